@@ sv/reader_frame_checker_defines.svh @@
// ----------------------------------------------------------------------------
// reader_frame_checker_defines
// assertion macros shared by the checker files
// ----------------------------------------------------------------------------
`ifndef READER_FRAME_CHECKER_DEFINES_SVH
`define READER_FRAME_CHECKER_DEFINES_SVH

// same-cycle implication, off during reset
`define RFC_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rfc assertion failed");

// next-cycle implication, off during reset
`define RFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rfc assertion failed");

// next-cycle implication, also checked across reset
`define RFC_ASSERT_RESET(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rfc assertion failed");

`endif

@@ sv/rfc_pkg.sv @@
// ----------------------------------------------------------------------------
// rfc_pkg
// types and constants of the reader frame checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rfc_pkg;

  // report types
  localparam logic [7:0] TYPE_OUT = 8'h01;
  localparam logic [7:0] TYPE_IN  = 8'h03;

  // frame markers
  localparam logic [7:0] SOF_OUT = 8'hAA;
  localparam logic [7:0] EOF_OUT = 8'hBB;
  localparam logic [7:0] SOF_IN  = 8'h02;
  localparam logic [7:0] EOF_IN  = 8'h03;

  // known commands
  localparam logic [7:0] CMD_20 = 8'h20;
  localparam logic [7:0] CMD_21 = 8'h21;
  localparam logic [7:0] CMD_25 = 8'h25;
  localparam logic [7:0] CMD_87 = 8'h87;
  localparam logic [7:0] CMD_88 = 8'h88;
  localparam logic [7:0] CMD_89 = 8'h89;

  // status codes
  localparam logic [7:0] STS_GOOD       = 8'h00;
  localparam logic [7:0] STS_READER_ERR = 8'h01;

  // verdict codes
  localparam logic [3:0] VERDICT_OK     = 4'd0;
  localparam logic [3:0] VERDICT_CHECK  = 4'd1;
  localparam logic [3:0] VERDICT_TYPE   = 4'd2;
  localparam logic [3:0] VERDICT_START  = 4'd3;
  localparam logic [3:0] VERDICT_END    = 4'd4;
  localparam logic [3:0] VERDICT_CMD    = 4'd5;
  localparam logic [3:0] VERDICT_FAIL   = 4'd6;
  localparam logic [3:0] VERDICT_STATUS = 4'd7;
  localparam logic [3:0] VERDICT_LENGTH = 4'd8;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // byte positions within a report
  localparam int unsigned POS_W = 9;
  localparam logic [POS_W-1:0] POS_SOF     = 9'd8;
  localparam logic [POS_W-1:0] POS_STATION = 9'd9;
  localparam logic [POS_W-1:0] POS_LEN     = 9'd10;
  localparam logic [POS_W-1:0] POS_CODE    = 9'd11;
  localparam logic [POS_W-1:0] POS_PAYLOAD = 9'd12;

  // queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  typedef struct packed {
    logic       is_verdict;
    logic       force_len;
    logic [7:0] data;
    logic [7:0] index;
    logic [7:0] ptype;
    logic [7:0] smark;
    logic [7:0] code;
    logic [7:0] chk;
    logic [7:0] xr;
    logic [7:0] detail;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic known_command(input logic [7:0] c);
    return c == CMD_20 || c == CMD_21 || c == CMD_25 ||
           c == CMD_87 || c == CMD_88 || c == CMD_89;
  endfunction

endpackage

@@ sv/rfc_if.sv @@
// ----------------------------------------------------------------------------
// rfc_if
// channel interfaces of the reader frame checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] report_byte;
  logic       report_start;

  modport source (output valid, output report_byte, output report_start, input ready);
  modport sink   (input valid, input report_byte, input report_start, output ready);
endinterface

interface rfc_out_if;
  logic       valid;
  logic       ready;
  logic       item_kind;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic [3:0] verdict;
  logic       direction;
  logic [7:0] code_value;
  logic [7:0] fail_detail;

  modport source (output valid, output item_kind, output payload_byte, output payload_index,
                  output verdict, output direction, output code_value, output fail_detail,
                  input ready);
  modport sink   (input valid, input item_kind, input payload_byte, input payload_index,
                  input verdict, input direction, input code_value, input fail_detail,
                  output ready);
endinterface

@@ sv/reader_frame_checker.sv @@
// ----------------------------------------------------------------------------
// reader_frame_checker
// Checks the frames carried in card reader feature reports, one report byte
// per transaction, and returns a tentative transaction for each payload byte
// of an incoming frame and a verdict transaction when a frame ends, has a bad
// length or is cut short by a new report. Bytes are taken one per cycle with
// no gaps; in_bus.ready drops only when the four-entry job queue between the
// parsing front and the judging back is full, which happens only while the
// result side stalls. A result that a byte causes passes through the job queue
// and then the output register before it appears on out_bus.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module reader_frame_checker #(
  parameter int unsigned REPORT_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  rfc_in_if.sink      in_bus,
  rfc_out_if.source   out_bus
);

  logic              push;
  logic              pop;
  rfc_pkg::job_t     push_job;
  rfc_pkg::job_t     head;
  rfc_pkg::q_stat_t  q_stat;

  rfc_front #(
    .REPORT_BYTES (REPORT_BYTES)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .q_stat (q_stat),
    .push   (push),
    .job    (push_job)
  );

  rfc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  rfc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_stat  (q_stat),
    .pop     (pop),
    .out_bus (out_bus)
  );

endmodule

@@ sv/rfc_front.sv @@
// ----------------------------------------------------------------------------
// rfc_front
// accepts report bytes, tracks the frame and queues payload and verdict jobs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfc_front #(
  parameter int unsigned REPORT_BYTES = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  rfc_in_if.sink            in_bus,
  input  rfc_pkg::q_stat_t  q_stat,
  output logic              push,
  output rfc_pkg::job_t     job
);

  localparam logic [10:0] REPORT_LIMIT = 11'(REPORT_BYTES);

  logic [rfc_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic                      active_r, active_nxt;
  logic [7:0]                type_r, type_nxt;
  logic [7:0]                len_r, len_nxt;
  logic [7:0]                xor_r, xor_nxt;
  logic [7:0]                smark_r, smark_nxt;
  logic [7:0]                code_r, code_nxt;
  logic [7:0]                chk_r, chk_nxt;
  logic [7:0]                first_r, first_nxt;

  logic                      accept;
  logic [7:0]                b;
  logic [10:0]               len_end;
  logic [rfc_pkg::POS_W-1:0] pay_last;
  logic [rfc_pkg::POS_W-1:0] chk_pos;
  logic [rfc_pkg::POS_W-1:0] idx_w;

  assign in_bus.ready = !q_stat.full;
  assign accept       = in_bus.valid && in_bus.ready;
  assign b            = in_bus.report_byte;
  assign len_end      = {3'b000, b} + 11'd12;
  assign pay_last     = {1'b0, len_r} + rfc_pkg::POS_LEN;
  assign chk_pos      = {1'b0, len_r} + rfc_pkg::POS_CODE;
  assign idx_w        = pos_r - rfc_pkg::POS_PAYLOAD;

  always_comb begin
    pos_nxt    = pos_r;
    active_nxt = active_r;
    type_nxt   = type_r;
    len_nxt    = len_r;
    xor_nxt    = xor_r;
    smark_nxt  = smark_r;
    code_nxt   = code_r;
    chk_nxt    = chk_r;
    first_nxt  = first_r;
    push       = 1'b0;
    job        = '0;
    if (accept) begin
      if (in_bus.report_start) begin
        if (active_r) begin
          push           = 1'b1;
          job.is_verdict = 1'b1;
          job.force_len  = 1'b1;
          job.ptype      = type_r;
          job.code       = code_r;
        end
        type_nxt   = b;
        pos_nxt    = 9'd1;
        active_nxt = 1'b1;
        len_nxt    = '0;
        xor_nxt    = '0;
        smark_nxt  = '0;
        code_nxt   = '0;
        chk_nxt    = '0;
        first_nxt  = '0;
      end else if (active_r) begin
        pos_nxt = pos_r + 9'd1;
        priority if (pos_r < rfc_pkg::POS_SOF) begin
        end else if (pos_r == rfc_pkg::POS_SOF) begin
          smark_nxt = b;
        end else if (pos_r == rfc_pkg::POS_STATION) begin
          xor_nxt = xor_r ^ b;
        end else if (pos_r == rfc_pkg::POS_LEN) begin
          len_nxt = b;
          xor_nxt = xor_r ^ b;
          if (b == 8'd0 || len_end >= REPORT_LIMIT) begin
            active_nxt     = 1'b0;
            push           = 1'b1;
            job.is_verdict = 1'b1;
            job.force_len  = 1'b1;
            job.ptype      = type_r;
            job.code       = code_r;
          end
        end else if (pos_r == rfc_pkg::POS_CODE) begin
          code_nxt = b;
          xor_nxt  = xor_r ^ b;
        end else if (pos_r <= pay_last) begin
          xor_nxt = xor_r ^ b;
          if (pos_r == rfc_pkg::POS_PAYLOAD) begin
            first_nxt = b;
          end
          if (type_r == rfc_pkg::TYPE_IN) begin
            push      = 1'b1;
            job.data  = b;
            job.index = idx_w[7:0];
          end
        end else if (pos_r == chk_pos) begin
          chk_nxt = b;
        end else begin
          active_nxt     = 1'b0;
          push           = 1'b1;
          job.is_verdict = 1'b1;
          job.data       = b;
          job.ptype      = type_r;
          job.smark      = smark_r;
          job.code       = code_r;
          job.chk        = chk_r;
          job.xr         = xor_r;
          job.detail     = (len_r >= 8'd2) ? first_r : 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      active_r <= 1'b0;
      type_r   <= '0;
      len_r    <= '0;
      xor_r    <= '0;
      smark_r  <= '0;
      code_r   <= '0;
      chk_r    <= '0;
      first_r  <= '0;
    end else begin
      pos_r    <= pos_nxt;
      active_r <= active_nxt;
      type_r   <= type_nxt;
      len_r    <= len_nxt;
      xor_r    <= xor_nxt;
      smark_r  <= smark_nxt;
      code_r   <= code_nxt;
      chk_r    <= chk_nxt;
      first_r  <= first_nxt;
    end
  end

endmodule

@@ sv/rfc_queue.sv @@
// ----------------------------------------------------------------------------
// rfc_queue
// small job queue between the front and the back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rfc_pkg::job_t     push_job,
  input  logic              pop,
  output rfc_pkg::job_t     head,
  output rfc_pkg::q_stat_t  q_stat
);

  rfc_pkg::job_t                 slot_r [rfc_pkg::QDEPTH];
  logic [rfc_pkg::QPTR_W-1:0]    wr_r, wr_nxt;
  logic [rfc_pkg::QPTR_W-1:0]    rd_r, rd_nxt;
  logic [rfc_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  logic                          do_push;
  logic                          do_pop;

  assign q_stat.full  = cnt_r == rfc_pkg::QCNT_W'(rfc_pkg::QDEPTH);
  assign q_stat.empty = cnt_r == '0;
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = slot_r[rd_r];

  always_comb begin
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    unique case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ sv/rfc_back.sv @@
// ----------------------------------------------------------------------------
// rfc_back
// judges queued jobs and holds the result transaction in an output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  rfc_pkg::job_t     head,
  input  rfc_pkg::q_stat_t  q_stat,
  output logic              pop,
  rfc_out_if.source         out_bus
);

  logic       valid_r;
  logic       kind_r, kind_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic [7:0] index_r, index_nxt;
  logic [3:0] verdict_r, verdict_nxt;
  logic       dir_r, dir_nxt;
  logic [7:0] code_r, code_nxt;
  logic [7:0] detail_r, detail_nxt;

  function automatic logic [3:0] judge(input rfc_pkg::job_t j);
    logic [3:0] v;
    if (j.chk != j.xr) begin
      v = rfc_pkg::VERDICT_CHECK;
    end else if (j.ptype != rfc_pkg::TYPE_OUT && j.ptype != rfc_pkg::TYPE_IN) begin
      v = rfc_pkg::VERDICT_TYPE;
    end else if (j.ptype == rfc_pkg::TYPE_OUT) begin
      if (j.smark != rfc_pkg::SOF_OUT) begin
        v = rfc_pkg::VERDICT_START;
      end else if (j.data != rfc_pkg::EOF_OUT) begin
        v = rfc_pkg::VERDICT_END;
      end else if (!rfc_pkg::known_command(j.code)) begin
        v = rfc_pkg::VERDICT_CMD;
      end else begin
        v = rfc_pkg::VERDICT_OK;
      end
    end else if (j.smark != rfc_pkg::SOF_IN) begin
      v = rfc_pkg::VERDICT_START;
    end else if (j.data != rfc_pkg::EOF_IN) begin
      v = rfc_pkg::VERDICT_END;
    end else if (j.code == rfc_pkg::STS_READER_ERR) begin
      v = rfc_pkg::VERDICT_FAIL;
    end else if (j.code != rfc_pkg::STS_GOOD) begin
      v = rfc_pkg::VERDICT_STATUS;
    end else begin
      v = rfc_pkg::VERDICT_OK;
    end
    return v;
  endfunction

  assign pop = !q_stat.empty && (!valid_r || out_bus.ready);

  always_comb begin
    if (head.is_verdict) begin
      kind_nxt    = rfc_pkg::KIND_VERDICT;
      byte_nxt    = '0;
      index_nxt   = '0;
      verdict_nxt = head.force_len ? rfc_pkg::VERDICT_LENGTH : judge(head);
      dir_nxt     = head.ptype == rfc_pkg::TYPE_IN;
      code_nxt    = head.code;
      detail_nxt  = head.detail;
    end else begin
      kind_nxt    = rfc_pkg::KIND_PAYLOAD;
      byte_nxt    = head.data;
      index_nxt   = head.index;
      verdict_nxt = rfc_pkg::VERDICT_OK;
      dir_nxt     = 1'b1;
      code_nxt    = '0;
      detail_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r    <= kind_nxt;
      byte_r    <= byte_nxt;
      index_r   <= index_nxt;
      verdict_r <= verdict_nxt;
      dir_r     <= dir_nxt;
      code_r    <= code_nxt;
      detail_r  <= detail_nxt;
    end
  end

  assign out_bus.valid         = valid_r;
  assign out_bus.item_kind     = kind_r;
  assign out_bus.payload_byte  = byte_r;
  assign out_bus.payload_index = index_r;
  assign out_bus.verdict       = verdict_r;
  assign out_bus.direction     = dir_r;
  assign out_bus.code_value    = code_r;
  assign out_bus.fail_detail   = detail_r;

endmodule

@@ sv/rfc_port_checker.sv @@
// ----------------------------------------------------------------------------
// rfc_port_checker
// port-level checks on the result channel of the reader frame checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "reader_frame_checker_defines.svh"

module rfc_port_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_item_kind,
  input logic [7:0] out_payload_byte,
  input logic [7:0] out_payload_index,
  input logic [3:0] out_verdict,
  input logic       out_direction,
  input logic [7:0] out_code_value,
  input logic [7:0] out_fail_detail
);

  // stalled transaction stays
  `RFC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_item_kind) && $stable(out_payload_byte) &&
    $stable(out_payload_index) && $stable(out_verdict))
  // stalled verdict fields stay
  `RFC_ASSERT_NEXT(a_out_hold_b, out_valid && !out_ready,
    $stable(out_direction) && $stable(out_code_value) && $stable(out_fail_detail))
  // payload transactions are incoming with clear verdict fields
  `RFC_ASSERT_IMPLY(a_payload_fmt, out_valid && out_item_kind == rfc_pkg::KIND_PAYLOAD,
    out_direction && out_verdict == rfc_pkg::VERDICT_OK && out_code_value == 8'd0 &&
    out_fail_detail == 8'd0 && out_payload_index <= 8'd253)
  // verdict transactions carry a known code and no payload byte
  `RFC_ASSERT_IMPLY(a_verdict_fmt, out_valid && out_item_kind == rfc_pkg::KIND_VERDICT,
    out_verdict <= rfc_pkg::VERDICT_LENGTH && out_payload_byte == 8'd0 &&
    out_payload_index == 8'd0)
  // nothing is offered right after reset
  `RFC_ASSERT_RESET(a_reset_idle, !rst_n, !out_valid)

endmodule

bind reader_frame_checker rfc_port_checker u_rfc_port_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_bus.valid),
  .out_ready         (out_bus.ready),
  .out_item_kind     (out_bus.item_kind),
  .out_payload_byte  (out_bus.payload_byte),
  .out_payload_index (out_bus.payload_index),
  .out_verdict       (out_bus.verdict),
  .out_direction     (out_bus.direction),
  .out_code_value    (out_bus.code_value),
  .out_fail_detail   (out_bus.fail_detail)
);

@@ bench/tb_reader_frame_checker.sv @@
// ----------------------------------------------------------------------------
// tb_reader_frame_checker
// Feeds report bytes to the frame checker and compares every result
// transaction against a cycle-free model of the frame parser. A short directed
// opening (stray bytes, zero length, a cut-short incoming frame) is followed
// by randomly built reports, mostly well formed, with corrupted markers,
// checks, codes, lengths and early restarts mixed in. Both sides idle in
// random bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_reader_frame_checker;

  localparam int unsigned REPORT_LEN = 256;
  localparam int unsigned RANDOM_BYTES = 1350;
  localparam int unsigned CALM_TAIL = 150;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 16;

  typedef struct {
    logic [7:0] data;
    logic       first;
  } report_byte_t;

  typedef struct {
    logic       kind;
    logic [7:0] data;
    logic [7:0] idx;
    logic [3:0] verdict;
    logic       dir;
    logic [7:0] code;
    logic [7:0] detail;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rfc_in_if  in_bus ();
  rfc_out_if out_bus ();

  reader_frame_checker #(.REPORT_BYTES(REPORT_LEN)) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  report_byte_t  report_bytes_q [$];
  frame_result_t results_due [$];

  // parser state
  int unsigned pos_r;
  bit          active_r;
  logic [7:0]  ptype_r, plen_r, xor_r, sof_r, code_r, chk_r, first_r;

  int unsigned total_bytes;
  int unsigned accepted_bytes;
  int unsigned mismatch_count;
  int unsigned payload_seen;
  int unsigned verdict_tally [0:8];
  int unsigned quiet_cycles;
  int unsigned reset_count;
  int unsigned in_gap, out_stall, mode_timer;
  bit          idle_enabled;
  bit          in_taken;

  initial begin
    in_bus.valid = 1'b0;
    in_bus.report_byte = 8'h00;
    in_bus.report_start = 1'b0;
    out_bus.ready = 1'b0;
  end

  function automatic logic is_known_command(logic [7:0] c);
    case (c)
      rfc_pkg::CMD_20, rfc_pkg::CMD_21, rfc_pkg::CMD_25,
      rfc_pkg::CMD_87, rfc_pkg::CMD_88, rfc_pkg::CMD_89: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] pick_command();
    case ($urandom_range(0, 5))
      0: return rfc_pkg::CMD_20;
      1: return rfc_pkg::CMD_21;
      2: return rfc_pkg::CMD_25;
      3: return rfc_pkg::CMD_87;
      4: return rfc_pkg::CMD_88;
      default: return rfc_pkg::CMD_89;
    endcase
  endfunction

  function automatic logic [3:0] rate_frame(logic [7:0] eof_b);
    if (chk_r != xor_r) return rfc_pkg::VERDICT_CHECK;
    if (ptype_r != rfc_pkg::TYPE_OUT && ptype_r != rfc_pkg::TYPE_IN)
      return rfc_pkg::VERDICT_TYPE;
    if (ptype_r == rfc_pkg::TYPE_OUT) begin
      if (sof_r != rfc_pkg::SOF_OUT) return rfc_pkg::VERDICT_START;
      if (eof_b != rfc_pkg::EOF_OUT) return rfc_pkg::VERDICT_END;
      if (!is_known_command(code_r)) return rfc_pkg::VERDICT_CMD;
      return rfc_pkg::VERDICT_OK;
    end
    if (sof_r != rfc_pkg::SOF_IN) return rfc_pkg::VERDICT_START;
    if (eof_b != rfc_pkg::EOF_IN) return rfc_pkg::VERDICT_END;
    if (code_r == rfc_pkg::STS_READER_ERR) return rfc_pkg::VERDICT_FAIL;
    if (code_r != rfc_pkg::STS_GOOD) return rfc_pkg::VERDICT_STATUS;
    return rfc_pkg::VERDICT_OK;
  endfunction

  function automatic void post_verdict(logic [3:0] v, logic [7:0] detail);
    frame_result_t r;
    r.kind = rfc_pkg::KIND_VERDICT;
    r.data = 8'h00;
    r.idx = 8'h00;
    r.verdict = v;
    r.dir = (ptype_r == rfc_pkg::TYPE_IN);
    r.code = code_r;
    r.detail = detail;
    results_due.push_back(r);
  endfunction

  // advance the parser by one accepted report byte
  function automatic void absorb_byte(logic [7:0] b, logic first);
    int unsigned p;
    int unsigned len;
    frame_result_t r;
    if (first) begin
      if (active_r) post_verdict(rfc_pkg::VERDICT_LENGTH, 8'h00);
      ptype_r = b;
      pos_r = 1;
      active_r = 1'b1;
      plen_r = 8'h00;
      xor_r = 8'h00;
      sof_r = 8'h00;
      code_r = 8'h00;
      chk_r = 8'h00;
      first_r = 8'h00;
    end else if (active_r) begin
      p = pos_r;
      pos_r = (pos_r + 1) & 9'h1FF;
      len = plen_r;
      if (p < rfc_pkg::POS_SOF) begin
      end else if (p == rfc_pkg::POS_SOF) begin
        sof_r = b;
      end else if (p == rfc_pkg::POS_STATION) begin
        xor_r ^= b;
      end else if (p == rfc_pkg::POS_LEN) begin
        plen_r = b;
        xor_r ^= b;
        if (b == 8'h00 || 12 + int'(b) >= REPORT_LEN) begin
          active_r = 1'b0;
          post_verdict(rfc_pkg::VERDICT_LENGTH, 8'h00);
        end
      end else if (p == rfc_pkg::POS_CODE) begin
        code_r = b;
        xor_r ^= b;
      end else if (p <= 10 + len) begin
        xor_r ^= b;
        if (p == rfc_pkg::POS_PAYLOAD) first_r = b;
        if (ptype_r == rfc_pkg::TYPE_IN) begin
          r.kind = rfc_pkg::KIND_PAYLOAD;
          r.data = b;
          r.idx = 8'(p - 12);
          r.verdict = rfc_pkg::VERDICT_OK;
          r.dir = 1'b1;
          r.code = 8'h00;
          r.detail = 8'h00;
          results_due.push_back(r);
        end
      end else if (p == 11 + len) begin
        chk_r = b;
      end else begin
        active_r = 1'b0;
        post_verdict(rate_frame(b), (len >= 2) ? first_r : 8'h00);
      end
    end
  endfunction

  function automatic void queue_byte(logic [7:0] b, logic first);
    report_byte_t t;
    t.data = b;
    t.first = first;
    report_bytes_q.push_back(t);
  endfunction

  // one report, mostly well formed, with occasional corruption or truncation
  function automatic void queue_random_report();
    logic [7:0] ptype, len, code, xr, b;
    logic [7:0] body [$];
    int unsigned r, keep;
    bit inbound;
    r = $urandom_range(0, 19);
    ptype = (r < 9) ? rfc_pkg::TYPE_OUT : (r < 18) ? rfc_pkg::TYPE_IN : 8'($urandom);
    inbound = (ptype == rfc_pkg::TYPE_IN);
    repeat (7) body.push_back(8'($urandom));
    if ($urandom_range(0, 15) == 0) body.push_back(8'($urandom));
    else body.push_back(inbound ? rfc_pkg::SOF_IN : rfc_pkg::SOF_OUT);
    b = 8'($urandom);
    body.push_back(b);
    xr = b;
    r = $urandom_range(0, 49);
    if (r == 0) len = 8'h00;
    else if (r == 1) len = 8'($urandom_range(244, 255));
    else if (r == 2) len = $urandom_range(0, 1) ? 8'd243 : 8'($urandom_range(9, 242));
    else len = 8'($urandom_range(1, 8));
    body.push_back(len);
    xr ^= len;
    if (len == 8'h00 || len > 8'd243) begin
      repeat ($urandom_range(0, 3)) body.push_back(8'($urandom));
    end else begin
      if (inbound) begin
        r = $urandom_range(0, 9);
        code = (r < 6) ? rfc_pkg::STS_GOOD : (r < 8) ? rfc_pkg::STS_READER_ERR : 8'($urandom);
      end else begin
        code = ($urandom_range(0, 7) != 0) ? pick_command() : 8'($urandom);
      end
      body.push_back(code);
      xr ^= code;
      repeat (len - 1) begin
        b = 8'($urandom);
        body.push_back(b);
        xr ^= b;
      end
      if ($urandom_range(0, 15) == 0) body.push_back(xr ^ 8'($urandom_range(1, 255)));
      else body.push_back(xr);
      if ($urandom_range(0, 15) == 0) body.push_back(8'($urandom));
      else body.push_back(inbound ? rfc_pkg::EOF_IN : rfc_pkg::EOF_OUT);
      repeat ($urandom_range(0, 2)) body.push_back(8'($urandom));
    end
    keep = ($urandom_range(0, 15) == 0) ? $urandom_range(0, body.size() - 1) : body.size();
    queue_byte(ptype, 1'b1);
    for (int i = 0; i < keep; i++) queue_byte(body[i], 1'b0);
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // driver: inputs and ready change on the falling edge
  always @(negedge clk) begin
    report_byte_t t;
    bit calm;
    if (reset_count < 9) begin
      reset_count++;
      if (reset_count == 9) rst_n <= 1'b1;
    end else begin
      if (mode_timer == 0) begin
        mode_timer = 200;
        idle_enabled = ($urandom_range(0, 2) != 0);
      end else begin
        mode_timer--;
      end
      calm = !idle_enabled || report_bytes_q.size() < CALM_TAIL;
      if (!in_bus.valid || in_taken) begin
        if (in_gap > 0) begin
          in_gap--;
          in_bus.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(0, 18);
          in_bus.valid <= 1'b0;
        end else if (report_bytes_q.size() > 0) begin
          t = report_bytes_q.pop_front();
          in_bus.valid <= 1'b1;
          in_bus.report_byte <= t.data;
          in_bus.report_start <= t.first;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        out_stall = $urandom_range(0, 18);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // monitor: sample both channels on the rising edge
  always @(posedge clk) begin
    frame_result_t want;
    bit in_fire, out_fire;
    in_fire = in_bus.valid && in_bus.ready;
    out_fire = out_bus.valid && out_bus.ready;
    in_taken <= in_fire;
    if (rst_n) begin
      if (in_fire) begin
        absorb_byte(in_bus.report_byte, in_bus.report_start);
        accepted_bytes++;
      end
      if (out_fire) begin
        if (out_bus.item_kind == rfc_pkg::KIND_PAYLOAD) payload_seen++;
        else if (out_bus.verdict <= rfc_pkg::VERDICT_LENGTH) verdict_tally[out_bus.verdict]++;
        if (results_due.size() == 0) begin
          $display("%0t: unexpected transaction, expected none actual kind %h verdict %h",
                   $time, out_bus.item_kind, out_bus.verdict);
          mismatch_count++;
        end else begin
          want = results_due.pop_front();
          check_field("item_kind", want.kind, out_bus.item_kind);
          check_field("payload_byte", want.data, out_bus.payload_byte);
          check_field("payload_index", want.idx, out_bus.payload_index);
          check_field("verdict", want.verdict, out_bus.verdict);
          check_field("direction", want.dir, out_bus.direction);
          check_field("code_value", want.code, out_bus.code_value);
          check_field("fail_detail", want.detail, out_bus.fail_detail);
        end
      end
      if (in_fire || out_fire) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: timeout, %0d transactions still awaited", $time, results_due.size());
        $display("reader_frame_checker verification failed");
        $finish;
      end
    end
  end

  initial begin
    // stray bytes before any report
    queue_byte(8'h5A, 1'b0);
    queue_byte(8'hA5, 1'b0);
    // outgoing report with zero length
    queue_byte(rfc_pkg::TYPE_OUT, 1'b1);
    repeat (7) queue_byte(8'hFF, 1'b0);
    queue_byte(rfc_pkg::SOF_OUT, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    // incoming frame with reader fail status, cut short by the next report
    queue_byte(rfc_pkg::TYPE_IN, 1'b1);
    repeat (7) queue_byte(8'h00, 1'b0);
    queue_byte(rfc_pkg::SOF_IN, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h02, 1'b0);
    queue_byte(rfc_pkg::STS_READER_ERR, 1'b0);
    queue_byte(8'hFF, 1'b0);
    total_bytes = report_bytes_q.size();
    while (report_bytes_q.size() < total_bytes + RANDOM_BYTES) queue_random_report();
    total_bytes = report_bytes_q.size();

    while (accepted_bytes < total_bytes || results_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d report bytes sent, %0d payload transactions checked", accepted_bytes,
             payload_seen);
    $display("verdicts ok %0d check %0d type %0d start %0d end %0d",
             verdict_tally[0], verdict_tally[1], verdict_tally[2], verdict_tally[3],
             verdict_tally[4]);
    $display("verdicts cmd %0d fail %0d status %0d len %0d",
             verdict_tally[5], verdict_tally[6], verdict_tally[7], verdict_tally[8]);
    if (mismatch_count == 0) begin
      $display("reader_frame_checker verification clean");
    end else begin
      $display("reader_frame_checker verification failed");
    end
    $finish;
  end

endmodule
